// File: sv/tmdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode display controller package
// Field widths, command and register codes, memory sizes and the palette
// shared by the controller's modules and channel interfaces.
// ----------------------------------------------------------------------------
package tmdc_pkg;

  // Beat field widths.
  localparam int CMD_W   = 3;
  localparam int PORT_W  = 16;
  localparam int ADDR_W  = 20;
  localparam int DATA_W  = 8;
  localparam int GCODE_W = 8;
  localparam int GROW_W  = 4;
  localparam int RGB_W   = 24;
  localparam int SX_W    = 11;
  localparam int SY_W    = 10;

  // Default geometry.
  localparam int DEF_COLUMNS     = 80;
  localparam int DEF_GLYPH_LINES = 16;

  // Video window and stores.
  localparam logic [ADDR_W-1:0] WIN_BASE = 20'hB8000;
  localparam logic [ADDR_W-1:0] WIN_END  = 20'hB8FA0;
  localparam int CELL_BYTES  = 4000;
  localparam int CELL_AW     = $clog2(CELL_BYTES);
  localparam int GLYPH_DEPTH = 4096;
  localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);

  // Index/data port pair and CRTC registers.
  localparam logic [PORT_W-1:0] IDX_PORT = 16'h03D4;
  localparam logic [PORT_W-1:0] DAT_PORT = 16'h03D5;
  localparam logic [DATA_W-1:0] REG_CUR_START = 8'h0A;
  localparam logic [DATA_W-1:0] REG_CUR_END   = 8'h0B;
  localparam logic [DATA_W-1:0] REG_POS_HI    = 8'h0E;
  localparam logic [DATA_W-1:0] REG_POS_LO    = 8'h0F;

  localparam int START_W = 6;
  localparam int END_W   = 5;
  localparam int POSH_W  = 3;
  localparam int POS_W   = POSH_W + DATA_W;

  localparam logic [START_W-1:0] CUR_START_RST = 6'd14;
  localparam logic [END_W-1:0]   CUR_END_RST   = 5'd15;

  typedef enum logic [CMD_W-1:0] {
    CMD_PORT_WR  = 3'd0,
    CMD_PORT_RD  = 3'd1,
    CMD_VID_WR   = 3'd2,
    CMD_VID_RD   = 3'd3,
    CMD_GLYPH_LD = 3'd4
  } cmd_t;

  // Cursor settings handed from the register file to the draw datapath.
  typedef struct packed {
    logic [START_W-1:0] start_line;
    logic [END_W-1:0]   end_line;
    logic [POS_W-1:0]   pos;
  } crtc_cursor_t;

  localparam logic [RGB_W-1:0] PALETTE [16] = '{
    24'h000000, 24'h0000cc, 24'h00cc00, 24'h00cccc,
    24'hcc0000, 24'hcc00cc, 24'hcccc00, 24'hcccccc,
    24'h888888, 24'h0000ff, 24'h00ff00, 24'h00ffff,
    24'hff0000, 24'hff00ff, 24'hffff00, 24'hffffff
  };

endpackage

// File: sv/tmdc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode display controller channels
// Valid/ready channel interfaces for command beats and result beats.
// ----------------------------------------------------------------------------
interface tmdc_in_if import tmdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [PORT_W-1:0]  port;
  logic [ADDR_W-1:0]  mem_address;
  logic [DATA_W-1:0]  data;
  logic [GCODE_W-1:0] glyph_code;
  logic [GROW_W-1:0]  glyph_row;
  logic               blink_phase;

  modport source (output valid, cmd, port, mem_address, data, glyph_code,
                  glyph_row, blink_phase, input ready);
  modport sink   (input valid, cmd, port, mem_address, data, glyph_code,
                  glyph_row, blink_phase, output ready);
endinterface

interface tmdc_out_if import tmdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [DATA_W-1:0] row_pixels;
  logic [RGB_W-1:0]  fore_rgb;
  logic [RGB_W-1:0]  back_rgb;
  logic [SX_W-1:0]   screen_x;
  logic [SY_W-1:0]   screen_y;
  logic              last;

  modport source (output valid, read_data, row_pixels, fore_rgb, back_rgb,
                  screen_x, screen_y, last, input ready);
  modport sink   (input valid, read_data, row_pixels, fore_rgb, back_rgb,
                  screen_x, screen_y, last, output ready);
endinterface

// File: sv/text_mode_display_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode display controller
// Character/attribute cell store, font store, CRTC cursor registers and a
// glyph-row renderer behind one command channel and one result channel.
// ----------------------------------------------------------------------------
// After reset the controller sweeps zeros through all CELL_BYTES bytes of the
// cell store and takes no command beat until the sweep is done. A port write
// or a glyph load returns nothing. A port read or a video memory read returns
// one beat from S_RESP once the result side is free; a memory read first
// passes through S_VRD to wait on the cell store's registered read port. A
// video memory write inside the window stores the byte and then renders the
// touched cell: the cell index is split into row and column by a reciprocal
// multiplication, quotient first and remainder in the cycle after, which runs
// while the character and attribute bytes are fetched from the single read
// port of the cell store in S_CHR and S_ATR; S_WAIT then starts the first
// font store read, and the glyph rows leave at one beat per cycle while the
// result side takes them, GLYPH_LINES beats in all, each paced by one read
// of the font store. A result beat sits in an output register, so stalls on
// the result side only hold the renderer in place.
// ----------------------------------------------------------------------------
module text_mode_display_controller import tmdc_pkg::*; #(
  parameter int COLUMNS     = DEF_COLUMNS,
  parameter int GLYPH_LINES = DEF_GLYPH_LINES
) (
  input  logic     clk,
  input  logic     rst_n,
  tmdc_in_if.sink  in_bus,
  tmdc_out_if.source out_bus
);

  // Geometry derived from the parameters.
  localparam int CELLS    = CELL_BYTES / 2;
  localparam int IDX_W    = CELL_AW - 1;
  localparam int ROWS_MAX = (CELLS + COLUMNS - 1) / COLUMNS;
  localparam int ROW_W    = $clog2(ROWS_MAX);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int LINE_W   = $clog2(GLYPH_LINES);
  localparam int YS_W     = $clog2(ROWS_MAX * GLYPH_LINES);
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(GLYPH_LINES - 1);

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_VRD   = 8'b0000_0100,
    S_RESP  = 8'b0000_1000,
    S_CHR   = 8'b0001_0000,
    S_ATR   = 8'b0010_0000,
    S_WAIT  = 8'b0100_0000,
    S_DRAW  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CELL_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Per-item working registers.
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              hit_r, hit_nxt;
  logic              vrd_in_r, vrd_in_nxt;
  logic [DATA_W-1:0] rdval_r, rdval_nxt;
  logic [DATA_W-1:0] chr_r, chr_nxt;
  logic [DATA_W-1:0] attr_r, attr_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [YS_W-1:0]   base_y_r, base_y_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;

  // Result beat register.
  logic [DATA_W-1:0] o_read_data_r;
  logic [DATA_W-1:0] o_pix_r;
  logic [RGB_W-1:0]  o_fore_r;
  logic [RGB_W-1:0]  o_back_r;
  logic [SX_W-1:0]   o_x_r;
  logic [SY_W-1:0]   o_y_r;
  logic              o_last_r;

  // Handshake and decode.
  logic               acc;
  logic               out_free;
  logic               in_win;
  logic [ADDR_W-1:0]  win_off;
  logic [CELL_AW-1:0] offset;
  logic               ld_rd;
  logic               ld_px;

  // Memory ports.
  logic               cell_we;
  logic [CELL_AW-1:0] cell_waddr;
  logic [DATA_W-1:0]  cell_wdata;
  logic               cell_re;
  logic [CELL_AW-1:0] cell_raddr;
  logic [DATA_W-1:0]  cell_q;

  logic                glyph_we;
  logic [GLYPH_AW-1:0] glyph_waddr;
  logic                glyph_re;
  logic [GLYPH_AW-1:0] glyph_raddr;
  logic [DATA_W-1:0]   glyph_q;

  // CRTC and divider.
  logic              crtc_wr;
  logic [DATA_W-1:0] crtc_rdata;
  crtc_cursor_t      cursor;

  logic              div_start;
  logic              div_busy;
  logic [ROW_W-1:0]  div_quo;
  logic [COL_W-1:0]  div_rem;

  // Glyph row datapath.
  logic              cur_line;
  logic [LINE_W-1:0] line_inc;
  logic [YS_W-1:0]   y_sum;

  assign in_bus.ready = (state_r == S_IDLE);
  assign acc          = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;

  // The window starts on a 4 KiB boundary, so the low address bits give the
  // byte offset once the range check passes.
  assign in_win  = (in_bus.mem_address >= WIN_BASE) && (in_bus.mem_address < WIN_END);
  assign win_off = in_bus.mem_address - WIN_BASE;
  assign offset  = win_off[CELL_AW-1:0];

  tmdc_crtc u_crtc (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (crtc_wr),
    .port   (in_bus.port),
    .wdata  (in_bus.data),
    .rdata  (crtc_rdata),
    .cursor (cursor)
  );

  tmdc_div #(
    .DIVISOR (COLUMNS),
    .NUM_W   (IDX_W),
    .QUO_W   (ROW_W),
    .REM_W   (COL_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (offset[CELL_AW-1:1]),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  tmdc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELL_BYTES)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_q)
  );

  tmdc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (GLYPH_DEPTH)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (glyph_we),
    .waddr (glyph_waddr),
    .wdata (in_bus.data),
    .re    (glyph_re),
    .raddr (glyph_raddr),
    .rdata (glyph_q)
  );

  assign glyph_waddr = {in_bus.glyph_code, in_bus.glyph_row};
  assign line_inc    = line_r + 1'b1;

  // A glyph line is inverted when the cell holds the cursor, the blink phase
  // was set on the write, and the line falls between start and end.
  assign cur_line = hit_r
                 && (START_W'(line_r) >= cursor.start_line)
                 && (START_W'(line_r) <= START_W'(cursor.end_line));
  assign y_sum    = base_y_r + YS_W'(line_r);

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    idx_nxt     = idx_r;
    hit_nxt     = hit_r;
    vrd_in_nxt  = vrd_in_r;
    rdval_nxt   = rdval_r;
    chr_nxt     = chr_r;
    attr_nxt    = attr_r;
    col_nxt     = col_r;
    base_y_nxt  = base_y_r;
    line_nxt    = line_r;
    cell_we     = 1'b0;
    cell_waddr  = offset;
    cell_wdata  = in_bus.data;
    cell_re     = 1'b0;
    cell_raddr  = offset;
    glyph_we    = 1'b0;
    glyph_re    = 1'b0;
    glyph_raddr = {chr_r, GROW_W'(line_inc)};
    crtc_wr     = 1'b0;
    div_start   = 1'b0;
    ld_rd       = 1'b0;
    ld_px       = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_cnt_r;
        cell_wdata = '0;
        if (clr_cnt_r == CELL_AW'(CELL_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (acc) begin
          unique case (in_bus.cmd)
            CMD_PORT_WR: begin
              crtc_wr = 1'b1;
            end
            CMD_PORT_RD: begin
              rdval_nxt = crtc_rdata;
              state_nxt = S_RESP;
            end
            CMD_VID_WR: begin
              if (in_win) begin
                cell_we   = 1'b1;
                idx_nxt   = offset[CELL_AW-1:1];
                // Row and column match exactly when the linear positions do.
                hit_nxt   = in_bus.blink_phase
                         && (POS_W'(offset[CELL_AW-1:1]) == cursor.pos);
                div_start = 1'b1;
                state_nxt = S_CHR;
              end
            end
            CMD_VID_RD: begin
              cell_re    = 1'b1;
              vrd_in_nxt = in_win;
              state_nxt  = S_VRD;
            end
            CMD_GLYPH_LD: begin
              glyph_we = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_VRD: begin
        rdval_nxt = vrd_in_r ? cell_q : '0;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          ld_rd     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CHR: begin
        cell_re    = 1'b1;
        cell_raddr = {idx_r, 1'b0};
        state_nxt  = S_ATR;
      end
      S_ATR: begin
        cell_re    = 1'b1;
        cell_raddr = {idx_r, 1'b1};
        chr_nxt    = cell_q;
        state_nxt  = S_WAIT;
      end
      S_WAIT: begin
        // The cell store read data holds the attribute byte until the next
        // read is issued.
        attr_nxt = cell_q;
        if (!div_busy) begin
          col_nxt     = div_rem;
          base_y_nxt  = YS_W'(div_quo * GLYPH_LINES);
          glyph_re    = 1'b1;
          glyph_raddr = {chr_r, GROW_W'(0)};
          line_nxt    = '0;
          state_nxt   = S_DRAW;
        end
      end
      S_DRAW: begin
        if (out_free) begin
          ld_px = 1'b1;
          if (line_r == LAST_LINE) begin
            state_nxt = S_IDLE;
          end else begin
            line_nxt = line_inc;
            glyph_re = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ld_rd || ld_px) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    hit_r    <= hit_nxt;
    vrd_in_r <= vrd_in_nxt;
    rdval_r  <= rdval_nxt;
    chr_r    <= chr_nxt;
    attr_r   <= attr_nxt;
    col_r    <= col_nxt;
    base_y_r <= base_y_nxt;
    line_r   <= line_nxt;
  end

  // Result beat register: read beats carry only the byte and the last flag.
  always_ff @(posedge clk) begin
    if (ld_rd) begin
      o_read_data_r <= rdval_r;
      o_pix_r       <= '0;
      o_fore_r      <= '0;
      o_back_r      <= '0;
      o_x_r         <= '0;
      o_y_r         <= '0;
      o_last_r      <= 1'b1;
    end else if (ld_px) begin
      o_read_data_r <= '0;
      o_pix_r       <= glyph_q ^ {DATA_W{cur_line}};
      o_fore_r      <= PALETTE[attr_r[3:0]];
      o_back_r      <= PALETTE[attr_r[7:4]];
      o_x_r         <= SX_W'(col_r) << 4;
      o_y_r         <= SY_W'({y_sum, 1'b0});
      o_last_r      <= (line_r == LAST_LINE);
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.read_data  = o_read_data_r;
  assign out_bus.row_pixels = o_pix_r;
  assign out_bus.fore_rgb   = o_fore_r;
  assign out_bus.back_rgb   = o_back_r;
  assign out_bus.screen_x   = o_x_r;
  assign out_bus.screen_y   = o_y_r;
  assign out_bus.last       = o_last_r;

endmodule

// File: sv/tmdc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/tmdc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant divider
// Reciprocal-multiply divider: the quotient is registered first, the remainder in the next cycle.
// ----------------------------------------------------------------------------
module tmdc_div #(
  parameter int DIVISOR = 80,
  parameter int NUM_W   = 11,
  parameter int QUO_W   = 5,
  parameter int REM_W   = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  output logic             busy,
  output logic [QUO_W-1:0] quo,
  output logic [REM_W-1:0] rem
);

  // Reciprocal scaled by 2**SHIFT and rounded up. The quotient is exact as
  // long as num * DIVISOR stays below 2**SHIFT.
  localparam int SHIFT  = 20;
  localparam int PROD_W = NUM_W + SHIFT;
  localparam logic [PROD_W-1:0] RECIP = PROD_W'((2 ** SHIFT + DIVISOR - 1) / DIVISOR);

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  back;

  assign prod = PROD_W'(num_r) * RECIP;
  assign back = NUM_W'(quo_r * DIVISOR);

  always_comb begin
    num_nxt = num_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    priority if (start) begin
      num_nxt = num;
      cnt_nxt = 2'd2;
    end else if (cnt_r == 2'd2) begin
      quo_nxt = prod[SHIFT +: QUO_W];
      cnt_nxt = 2'd1;
    end else if (cnt_r == 2'd1) begin
      rem_nxt = REM_W'(num_r - back);
      cnt_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// File: sv/tmdc_crtc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRTC register file
// Index/data port pair holding the cursor shape and position registers.
// ----------------------------------------------------------------------------
module tmdc_crtc import tmdc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [PORT_W-1:0] port,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata,
  output crtc_cursor_t      cursor
);

  logic [DATA_W-1:0]  index_r, index_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic [END_W-1:0]   end_r, end_nxt;
  logic [POSH_W-1:0]  pos_hi_r, pos_hi_nxt;
  logic [DATA_W-1:0]  pos_lo_r, pos_lo_nxt;
  logic [DATA_W-1:0]  echo_r, echo_nxt;

  always_comb begin
    index_nxt  = index_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    pos_hi_nxt = pos_hi_r;
    pos_lo_nxt = pos_lo_r;
    echo_nxt   = echo_r;
    if (wr_en) begin
      if (port == IDX_PORT) begin
        index_nxt = wdata;
      end else if (port == DAT_PORT) begin
        echo_nxt = wdata;
        unique case (index_r)
          REG_CUR_START: start_nxt  = wdata[START_W-1:0];
          REG_CUR_END:   end_nxt    = wdata[END_W-1:0];
          REG_POS_HI:    pos_hi_nxt = wdata[POSH_W-1:0];
          REG_POS_LO:    pos_lo_nxt = wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r  <= '0;
      start_r  <= CUR_START_RST;
      end_r    <= CUR_END_RST;
      pos_hi_r <= '0;
      pos_lo_r <= '0;
      echo_r   <= '0;
    end else begin
      index_r  <= index_nxt;
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      pos_hi_r <= pos_hi_nxt;
      pos_lo_r <= pos_lo_nxt;
      echo_r   <= echo_nxt;
    end
  end

  always_comb begin
    priority if (port == IDX_PORT) begin
      rdata = index_r;
    end else if (port == DAT_PORT) begin
      priority if (index_r == REG_CUR_START) begin
        rdata = DATA_W'(start_r);
      end else if (index_r == REG_CUR_END) begin
        rdata = DATA_W'(end_r);
      end else begin
        rdata = echo_r;
      end
    end else begin
      rdata = '0;
    end
  end

  assign cursor.start_line = start_r;
  assign cursor.end_line   = end_r;
  assign cursor.pos        = {pos_hi_r, pos_lo_r};

endmodule

// File: sv/tmdc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode display controller checker
// Port-level assertions on the controller, attached by a bind statement.
// ----------------------------------------------------------------------------
module tmdc_chk import tmdc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [CMD_W-1:0]  in_cmd,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_last,
  input logic [DATA_W-1:0] out_read_data,
  input logic [DATA_W-1:0] out_row_pixels
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // The cell store clearing sweep keeps the command side closed after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    disable iff (!rst_n) $past(!rst_n) |-> !in_ready)
    else $error("command beat offered acceptance during the clearing sweep");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_row_pixels) && $stable(out_last))
    else $error("result beat changed while stalled");

  // A read keeps the controller busy until its reply is registered.
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_cmd == CMD_PORT_RD || in_cmd == CMD_VID_RD) |=> !in_ready)
    else $error("command accepted while a read reply was pending");

  // A port write produces no result beat.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_cmd == CMD_PORT_WR && !out_valid |=> !out_valid)
    else $error("port write produced a result beat");

  // While a glyph row other than the final one waits, the renderer is busy.
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("command side open in the middle of a glyph row burst");

endmodule

bind text_mode_display_controller tmdc_chk u_tmdc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .in_cmd         (in_bus.cmd),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_last       (out_bus.last),
  .out_read_data  (out_bus.read_data),
  .out_row_pixels (out_bus.row_pixels)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode display controller testbench
// Streams port, video memory and font commands into the controller and
// checks every result beat against an in-bench model of the cell store,
// font store and cursor registers, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import tmdc_pkg::*;

  // Geometry of the instance under test (package defaults).
  localparam int COLS  = DEF_COLUMNS;
  localparam int LINES = DEF_GLYPH_LINES;
  localparam int CELLS = CELL_BYTES / 2;

  // Stimulus and run control.
  localparam int TARGET_CMDS  = 330;
  localparam int IDLE_PCT     = 16;
  localparam int STALL_LIMIT  = 20000;  // covers the clearing sweep
  localparam int DRAIN_CYCLES = 2 * LINES + 16;
  localparam int PRINT_CAP    = 100;

  // Command codes 5 to 7 are unassigned; the controller must ignore them.
  localparam logic [CMD_W-1:0] CMD_SPARE = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [PORT_W-1:0]  port;
    logic [ADDR_W-1:0]  mem_address;
    logic [DATA_W-1:0]  data;
    logic [GCODE_W-1:0] glyph_code;
    logic [GROW_W-1:0]  glyph_row;
    logic               blink_phase;
  } command_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] row_pixels;
    logic [RGB_W-1:0]  fore_rgb;
    logic [RGB_W-1:0]  back_rgb;
    logic [SX_W-1:0]   screen_x;
    logic [SY_W-1:0]   screen_y;
    logic              last;
  } beat_t;

  logic clk;
  logic rst_n;

  tmdc_in_if  cmd_ch ();
  tmdc_out_if res_ch ();

  text_mode_display_controller u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (cmd_ch),
    .out_bus (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Commands waiting to be driven, the beat on the bus, and the result
  // beats still owed by the controller, oldest first.
  command_t cmd_backlog [$];
  command_t in_flight;
  beat_t    due_beats [$];

  int accepted_cmds;
  int kind_count [8];
  int beats_checked;
  int mismatches;

  // Display model: the controller's visible state as the predictor sees it.
  logic [7:0]         cell_img [CELL_BYTES];
  logic [7:0]         font_img [GLYPH_DEPTH];
  logic [7:0]         crtc_index;
  logic [7:0]         echo_reg;
  logic [START_W-1:0] start_reg;
  logic [END_W-1:0]   end_reg;
  logic [POSH_W-1:0]  pos_hi_reg;
  logic [7:0]         pos_lo_reg;

  // Stimulus-side bookkeeping. A video write renders the cell's character,
  // and the font store is undefined until written, so the generator tracks
  // which glyph rows were loaded and only writes characters that are ready.
  bit         font_seen [GLYPH_DEPTH];
  bit         code_ok [256];
  logic [7:0] ready_codes [$];
  int         counted;

  // Both channels run without idling for a stretch in the middle of the run.
  function automatic bit steady();
    return accepted_cmds >= 150 && accepted_cmds < 240;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: applies one accepted command to the display model and queues
  // the result beats it causes.
  // ---------------------------------------------------------------------------
  task automatic predict_command(command_t c);
    logic       in_win;
    int         off;
    int         idx;
    int         col;
    int         row;
    int         cpos;
    logic [7:0] chr;
    logic [7:0] attr;
    logic [7:0] bits;
    logic       on_cursor;
    beat_t      b;
    in_win = (c.mem_address >= WIN_BASE) && (c.mem_address < WIN_END);
    b = '0;
    case (c.cmd)
      CMD_PORT_WR: begin
        if (c.port == IDX_PORT) begin
          crtc_index = c.data;
        end else if (c.port == DAT_PORT) begin
          case (crtc_index)
            REG_CUR_START: start_reg  = c.data[START_W-1:0];
            REG_CUR_END:   end_reg    = c.data[END_W-1:0];
            REG_POS_HI:    pos_hi_reg = c.data[POSH_W-1:0];
            REG_POS_LO:    pos_lo_reg = c.data;
            default: ;
          endcase
          // The data port echoes every write, whatever the index.
          echo_reg = c.data;
        end
      end
      CMD_PORT_RD: begin
        b.last = 1'b1;
        if (c.port == IDX_PORT) begin
          b.read_data = crtc_index;
        end else if (c.port == DAT_PORT) begin
          if (crtc_index == REG_CUR_START) b.read_data = {2'b00, start_reg};
          else if (crtc_index == REG_CUR_END) b.read_data = {3'b000, end_reg};
          else b.read_data = echo_reg;
        end
        due_beats.push_back(b);
      end
      CMD_VID_RD: begin
        b.last = 1'b1;
        if (in_win) b.read_data = cell_img[c.mem_address - WIN_BASE];
        due_beats.push_back(b);
      end
      CMD_VID_WR: begin
        if (in_win) begin
          off = int'(c.mem_address - WIN_BASE);
          cell_img[off] = c.data;
          idx  = off / 2;
          col  = idx % COLS;
          row  = idx / COLS;
          chr  = cell_img[2 * idx];
          attr = cell_img[2 * idx + 1];
          // A cursor position past the last cell lands on a row that does
          // not exist, so it never matches.
          cpos = int'({pos_hi_reg, pos_lo_reg});
          on_cursor = (cpos % COLS == col) && (cpos / COLS == row);
          for (int line = 0; line < LINES; line++) begin
            bits = font_img[{chr, line[3:0]}];
            // Cursor lines are inverted only while the blink phase shows the
            // cursor; a start line greater than the end line selects no line at all.
            if (c.blink_phase && on_cursor && line >= start_reg && line <= end_reg)
              bits = ~bits;
            b.read_data  = '0;
            b.row_pixels = bits;
            b.fore_rgb   = PALETTE[attr[3:0]];
            b.back_rgb   = PALETTE[attr[7:4]];
            b.screen_x   = SX_W'(16 * col);
            b.screen_y   = SY_W'(2 * (row * LINES + line));
            b.last       = (line == LINES - 1);
            due_beats.push_back(b);
          end
        end
      end
      CMD_GLYPH_LD: begin
        font_img[{c.glyph_code, c.glyph_row}] = c.data;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH at result beat %0d: %s", beats_checked, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_beat();
    beat_t got;
    beat_t want;
    got.read_data  = res_ch.read_data;
    got.row_pixels = res_ch.row_pixels;
    got.fore_rgb   = res_ch.fore_rgb;
    got.back_rgb   = res_ch.back_rgb;
    got.screen_x   = res_ch.screen_x;
    got.screen_y   = res_ch.screen_y;
    got.last       = res_ch.last;
    if (due_beats.size() == 0) begin
      report_mismatch("result beat with nothing outstanding");
    end else begin
      want = due_beats.pop_front();
      compare_field("read_data", got.read_data, want.read_data);
      compare_field("row_pixels", got.row_pixels, want.row_pixels);
      compare_field("fore_rgb", got.fore_rgb, want.fore_rgb);
      compare_field("back_rgb", got.back_rgb, want.back_rgb);
      compare_field("screen_x", got.screen_x, want.screen_x);
      compare_field("screen_y", got.screen_y, want.screen_y);
      compare_field("last", got.last, want.last);
    end
    beats_checked++;
  endtask

  // ---------------------------------------------------------------------------
  // Command driver. The beat on the bus is handed to the predictor at the
  // edge where it is taken; the next one is then put up, or valid drops
  // to idle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_command(in_flight);
        kind_count[in_flight.cmd]++;
        accepted_cmds++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_backlog.size() != 0 && (steady() || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_flight = cmd_backlog.pop_front();
          cmd_ch.valid       <= 1'b1;
          cmd_ch.cmd         <= in_flight.cmd;
          cmd_ch.port        <= in_flight.port;
          cmd_ch.mem_address <= in_flight.mem_address;
          cmd_ch.data        <= in_flight.data;
          cmd_ch.glyph_code  <= in_flight.glyph_code;
          cmd_ch.glyph_row   <= in_flight.glyph_row;
          cmd_ch.blink_phase <= in_flight.blink_phase;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Ready is withdrawn at random so that stalls land on
  // every phase of a glyph-row burst.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) check_beat();
      res_ch.ready <= steady() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: a long run of cycles with no beat on either channel means the
  // controller has hung or dropped results.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout after %0d quiet cycles, %0d result beats outstanding",
             STALL_LIMIT, due_beats.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders. Fields a command does not use are left random so that
  // every input bit toggles.
  // ---------------------------------------------------------------------------
  function automatic command_t random_command();
    command_t c;
    c.cmd         = CMD_W'($urandom);
    c.port        = PORT_W'($urandom);
    c.mem_address = ADDR_W'($urandom);
    c.data        = DATA_W'($urandom);
    c.glyph_code  = GCODE_W'($urandom);
    c.glyph_row   = GROW_W'($urandom);
    c.blink_phase = 1'($urandom);
    return c;
  endfunction

  // Commands the controller simply ignores do not count toward the target.
  task automatic queue_cmd(command_t c, bit counts);
    cmd_backlog.push_back(c);
    if (counts) counted++;
  endtask

  task automatic add_port_wr(logic [PORT_W-1:0] p, logic [DATA_W-1:0] d);
    command_t c;
    c = random_command();
    c.cmd  = CMD_PORT_WR;
    c.port = p;
    c.data = d;
    queue_cmd(c, p == IDX_PORT || p == DAT_PORT);
  endtask

  task automatic add_port_rd(logic [PORT_W-1:0] p);
    command_t c;
    c = random_command();
    c.cmd  = CMD_PORT_RD;
    c.port = p;
    queue_cmd(c, 1'b1);
  endtask

  task automatic set_crtc(logic [DATA_W-1:0] reg_idx, logic [DATA_W-1:0] d);
    add_port_wr(IDX_PORT, reg_idx);
    add_port_wr(DAT_PORT, d);
  endtask

  task automatic add_video_read(logic [ADDR_W-1:0] a);
    command_t c;
    c = random_command();
    c.cmd         = CMD_VID_RD;
    c.mem_address = a;
    queue_cmd(c, 1'b1);
  endtask

  // Raw video write; the caller guarantees the cell's character has a
  // fully loaded glyph.
  task automatic add_video_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d, bit blink);
    command_t c;
    bit       in_win;
    in_win = (a >= WIN_BASE) && (a < WIN_END);
    c = random_command();
    c.cmd         = CMD_VID_WR;
    c.mem_address = a;
    c.data        = d;
    c.blink_phase = blink;
    queue_cmd(c, in_win);
  endtask

  function automatic logic [7:0] pick_code();
    return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
  endfunction

  // Video write with random content, limited to characters whose glyph is
  // loaded. Attribute bytes are free; the cell's character is already legal.
  task automatic add_legal_video_write(logic [ADDR_W-1:0] a, bit blink);
    logic [7:0] d;
    d = 8'($urandom);
    if (a >= WIN_BASE && a < WIN_END && a[0] == 1'b0) d = pick_code();
    add_video_write(a, d, blink);
  endtask

  task automatic add_glyph_load(logic [7:0] code, logic [3:0] row, logic [7:0] d);
    command_t c;
    bit       all_rows;
    c = random_command();
    c.cmd        = CMD_GLYPH_LD;
    c.glyph_code = code;
    c.glyph_row  = row;
    c.data       = d;
    queue_cmd(c, 1'b1);
    font_seen[{code, row}] = 1'b1;
    if (!code_ok[code]) begin
      all_rows = 1'b1;
      for (int r = 0; r < LINES; r++) all_rows &= font_seen[{code, 4'(r)}];
      if (all_rows) begin
        code_ok[code] = 1'b1;
        ready_codes.push_back(code);
      end
    end
  endtask

  task automatic load_font(logic [7:0] code);
    for (int r = 0; r < LINES; r++) add_glyph_load(code, 4'(r), 8'($urandom));
  endtask

  task automatic add_spare_cmd();
    command_t c;
    c = random_command();
    c.cmd = CMD_SPARE + CMD_W'($urandom_range(0, 2));
    queue_cmd(c, 1'b0);
  endtask

  function automatic logic [ADDR_W-1:0] cell_addr(int cell_no, bit attr_byte);
    return WIN_BASE + ADDR_W'(2 * cell_no + attr_byte);
  endfunction

  // Cursor start/end values: mostly small line numbers with random upper
  // bits to exercise the masking, sometimes a fully random byte.
  function automatic logic [7:0] line_byte();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return {3'($urandom), 5'($urandom_range(0, 17))};
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int         pick;
    int         pos;
    int         cell_no;
    logic [7:0] code;

    rst_n              = 1'b0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.cmd         = '0;
    cmd_ch.port        = '0;
    cmd_ch.mem_address = '0;
    cmd_ch.data        = '0;
    cmd_ch.glyph_code  = '0;
    cmd_ch.glyph_row   = '0;
    cmd_ch.blink_phase = 1'b0;
    res_ch.ready       = 1'b0;

    // Model state after reset: cleared cell store, cursor on lines 14-15.
    for (int i = 0; i < CELL_BYTES; i++) cell_img[i] = '0;
    for (int i = 0; i < GLYPH_DEPTH; i++) begin
      font_img[i]  = '0;
      font_seen[i] = 1'b0;
    end
    for (int i = 0; i < 256; i++) code_ok[i] = 1'b0;
    crtc_index = '0;
    echo_reg   = '0;
    start_reg  = CUR_START_RST;
    end_reg    = CUR_END_RST;
    pos_hi_reg = '0;
    pos_lo_reg = '0;
    accepted_cmds = 0;
    beats_checked = 0;
    mismatches    = 0;
    counted       = 0;
    for (int i = 0; i < 8; i++) kind_count[i] = 0;

    // Every cell starts as character 0, so its glyph goes in before any
    // video write; the all-ones character is loaded for the extreme cases.
    load_font(8'h00);
    load_font(8'hFF);

    // Directed part. Reset values through the index/data pair first.
    add_port_rd(IDX_PORT);
    add_port_rd(DAT_PORT);
    add_port_wr(IDX_PORT, REG_CUR_START);
    add_port_rd(DAT_PORT);
    // Masking of the start and end lines.
    add_port_wr(DAT_PORT, 8'hFF);
    add_port_rd(DAT_PORT);
    set_crtc(REG_CUR_END, 8'hFF);
    add_port_rd(DAT_PORT);
    // Cursor over every line, on the first cell, shown and hidden.
    set_crtc(REG_CUR_START, 8'h00);
    add_video_write(WIN_BASE, 8'hFF, 1'b1);
    add_video_write(WIN_BASE + 1, 8'hFF, 1'b0);
    add_video_read(WIN_BASE);
    add_video_read(WIN_END - 1);
    add_video_read('1);
    // Writes just outside the window are dropped.
    add_video_write(WIN_BASE - 1, 8'hFF, 1'b1);
    add_video_write(WIN_END, 8'hFF, 1'b1);
    // Cursor on the last cell of the screen, high byte masked to three bits.
    set_crtc(REG_POS_HI, 8'hFF);
    set_crtc(REG_POS_LO, 8'hCF);
    add_video_write(WIN_END - 1, 8'h0F, 1'b1);
    // Start line below the end line selects nothing.
    set_crtc(REG_CUR_START, 8'd15);
    set_crtc(REG_CUR_END, 8'd3);
    add_video_write(WIN_END - 2, 8'h00, 1'b1);
    // Position past the screen matches no cell.
    set_crtc(REG_POS_LO, 8'hFF);
    set_crtc(REG_CUR_START, 8'd0);
    add_video_write(WIN_END - 2, 8'hFF, 1'b1);
    // Foreign ports read zero and ignore writes; the data port then returns the start line.
    add_port_rd(16'h0000);
    add_port_wr(16'hFFFF, 8'hAA);
    add_port_rd(16'hFFFF);
    add_port_rd(DAT_PORT);
    add_spare_cmd();

    // Random part, mostly well-formed cursor and render sequences.
    while (counted < TARGET_CMDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // Place the cursor, reshape it, then redraw the cursor cell.
        pos = ($urandom_range(0, 9) == 0) ? $urandom_range(CELLS, 2047)
                                          : $urandom_range(0, CELLS - 1);
        set_crtc(REG_POS_HI, {5'($urandom), 3'(pos >> 8)});
        set_crtc(REG_POS_LO, 8'(pos));
        if ($urandom_range(0, 1)) set_crtc(REG_CUR_START, line_byte());
        if ($urandom_range(0, 1)) set_crtc(REG_CUR_END, line_byte());
        cell_no = (pos < CELLS) ? pos : $urandom_range(0, CELLS - 1);
        add_legal_video_write(cell_addr(cell_no, 1'($urandom)), $urandom_range(0, 4) != 0);
      end else if (pick < 45) begin
        cell_no = $urandom_range(0, CELLS - 1);
        add_legal_video_write(cell_addr(cell_no, 1'($urandom)), 1'($urandom));
      end else if (pick < 52) begin
        // Load a whole glyph and put it on screen.
        code = 8'($urandom);
        load_font(code);
        add_video_write(cell_addr($urandom_range(0, CELLS - 1), 1'b0), code, 1'($urandom));
      end else if (pick < 67) begin
        if ($urandom_range(0, 3) == 0) add_video_read(ADDR_W'($urandom));
        else add_video_read(cell_addr($urandom_range(0, CELLS - 1), 1'($urandom)));
      end else if (pick < 82) begin
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 4))
            0: add_port_wr(IDX_PORT, REG_CUR_START);
            1: add_port_wr(IDX_PORT, REG_CUR_END);
            2: add_port_wr(IDX_PORT, REG_POS_HI);
            3: add_port_wr(IDX_PORT, REG_POS_LO);
            default: add_port_wr(IDX_PORT, 8'($urandom));
          endcase
        end
        case ($urandom_range(0, 2))
          0: add_port_rd(IDX_PORT);
          1: add_port_rd(DAT_PORT);
          default: add_port_rd(PORT_W'($urandom));
        endcase
      end else if (pick < 88) begin
        // Data port write under a random index: echo only, or a register.
        add_port_wr(DAT_PORT, 8'($urandom));
      end else begin
        // Noise: stray ports, stray glyph rows, unused codes, stray writes.
        case ($urandom_range(0, 3))
          0: add_port_wr(PORT_W'($urandom), 8'($urandom));
          1: add_glyph_load(8'($urandom), 4'($urandom), 8'($urandom));
          2: add_spare_cmd();
          default: add_legal_video_write(ADDR_W'($urandom), 1'($urandom));
        endcase
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every command taken and every owed beat received, then a final
    // wait to catch stray beats.
    while (cmd_backlog.size() != 0 || cmd_ch.valid || due_beats.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("commands taken: %0d port writes, %0d port reads, %0d video writes, %0d video reads, %0d glyph loads, %0d unused codes",
             kind_count[CMD_PORT_WR], kind_count[CMD_PORT_RD], kind_count[CMD_VID_WR],
             kind_count[CMD_VID_RD], kind_count[CMD_GLYPH_LD],
             accepted_cmds - kind_count[CMD_PORT_WR] - kind_count[CMD_PORT_RD]
             - kind_count[CMD_VID_WR] - kind_count[CMD_VID_RD] - kind_count[CMD_GLYPH_LD]);
    $display("result beats checked: %0d, mismatches: %0d", beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
